>>> rtl/core/lmfb_pkg.sv
package lmfb_pkg;

  localparam int MAX_DISPLAYS = 8;
  localparam int ROWS         = 8;
  localparam int STORE_DEPTH  = MAX_DISPLAYS * ROWS;
  localparam int DISP_W       = $clog2(MAX_DISPLAYS);
  localparam int ROW_W        = $clog2(ROWS);
  localparam int IDX_W        = DISP_W + ROW_W;

  localparam logic [3:0] DISPLAY_COUNT_RST = 4'd4;

  // Command codes
  localparam logic [1:0] MODE_PIXEL  = 2'd0;
  localparam logic [1:0] MODE_FLUSH  = 2'd1;
  localparam logic [1:0] MODE_BCAST  = 2'd2;
  localparam logic [1:0] MODE_SINGLE = 2'd3;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_WORD   = 1'b1;

  // Status codes
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_INVALID = 1'b1;

  typedef struct packed {
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       wr_data;
  } lmfb_store_req_t;

endpackage

>>> rtl/core/lmfb_store.sv
module lmfb_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lmfb_pkg::lmfb_store_req_t req,
  output logic [7:0]                rd_data
);

  logic [7:0]                       mem [lmfb_pkg::STORE_DEPTH];
  logic [lmfb_pkg::STORE_DEPTH-1:0] valid_r;
  logic [7:0]                       rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= valid_r[req.addr] ? mem[req.addr] : 8'd0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/core/lmfb_seq.sv
module lmfb_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lmfb_pkg::DISP_W-1:0]   last_disp,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [7:0]                    in_pixel_column,
  input  logic [7:0]                    in_pixel_row,
  input  logic [7:0]                    in_pixel_value,
  input  logic [3:0]                    in_reg_addr,
  input  logic [7:0]                    in_reg_data,
  input  logic [7:0]                    in_display_index,
  output lmfb_pkg::lmfb_store_req_t     store_req,
  input  logic [7:0]                    store_rd_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [3:0]                    out_addr,
  output logic [7:0]                    out_data,
  output logic                          out_frame_end,
  output logic                          out_last,
  output logic                          out_status
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_STAT    = 3'd1;
  localparam logic [2:0] S_PIX     = 3'd2;
  localparam logic [2:0] S_FL_RD   = 3'd3;
  localparam logic [2:0] S_FL_EMIT = 3'd4;
  localparam logic [2:0] S_WORDS   = 3'd5;

  logic [2:0]                  state_r, state_nxt;
  logic                        bcast_r, bcast_nxt;
  logic [lmfb_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [lmfb_pkg::DISP_W-1:0] disp_r, disp_nxt;
  logic [lmfb_pkg::DISP_W-1:0] dsp_r, dsp_nxt;
  logic [3:0]                  raddr_r, raddr_nxt;
  logic [7:0]                  rdata_r, rdata_nxt;
  logic [2:0]                  bit_r, bit_nxt;
  logic                        val_r, val_nxt;
  logic                        bad_r, bad_nxt;
  logic [lmfb_pkg::IDX_W-1:0]  pix_idx_r, pix_idx_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       kind_r, kind_nxt;
  logic [3:0] oaddr_r, oaddr_nxt;
  logic [7:0] odata_r, odata_nxt;
  logic       fend_r, fend_nxt;
  logic       last_r, last_nxt;
  logic       status_r, status_nxt;

  logic       out_free;
  logic       accept;
  logic       disp_end;
  logic       pix_bad;
  logic       dsp_bad;
  logic [7:0] pix_mask;
  logic [7:0] pix_byte;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);
  // shared compare: current display is the last one in use
  assign disp_end = (disp_r == last_disp);

  // x/8 >= count, y >= 8, value other than 0 or 1
  assign pix_bad = (in_pixel_column[7:3] > {2'b00, last_disp}) ||
                   (in_pixel_row[7:3] != 5'd0) || (in_pixel_value[7:1] != 7'd0);
  assign dsp_bad = (in_display_index > {5'd0, last_disp});

  assign pix_mask = 8'h80 >> bit_r;
  assign pix_byte = val_r ? (store_rd_data | pix_mask) : (store_rd_data & ~pix_mask);

  always_comb begin
    state_nxt     = state_r;
    bcast_nxt     = bcast_r;
    row_nxt       = row_r;
    disp_nxt      = disp_r;
    dsp_nxt       = dsp_r;
    raddr_nxt     = raddr_r;
    rdata_nxt     = rdata_r;
    bit_nxt       = bit_r;
    val_nxt       = val_r;
    bad_nxt       = bad_r;
    pix_idx_nxt   = pix_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    oaddr_nxt     = oaddr_r;
    odata_nxt     = odata_r;
    fend_nxt      = fend_r;
    last_nxt      = last_r;
    status_nxt    = status_r;
    store_req     = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          bcast_nxt   = (in_mode == lmfb_pkg::MODE_BCAST);
          raddr_nxt   = in_reg_addr;
          rdata_nxt   = in_reg_data;
          dsp_nxt     = in_display_index[lmfb_pkg::DISP_W-1:0];
          bit_nxt     = in_pixel_column[2:0];
          val_nxt     = in_pixel_value[0];
          pix_idx_nxt = {in_pixel_column[lmfb_pkg::DISP_W+2:3],
                         in_pixel_row[lmfb_pkg::ROW_W-1:0]};
          row_nxt     = '0;
          disp_nxt    = '0;
          case (in_mode)
            lmfb_pkg::MODE_PIXEL: begin
              if (pix_bad) begin
                bad_nxt   = 1'b1;
                state_nxt = S_STAT;
              end else begin
                store_req.rd_en = 1'b1;
                store_req.addr  = {in_pixel_column[lmfb_pkg::DISP_W+2:3],
                                   in_pixel_row[lmfb_pkg::ROW_W-1:0]};
                state_nxt       = S_PIX;
              end
            end
            lmfb_pkg::MODE_FLUSH: begin
              state_nxt = S_FL_RD;
            end
            lmfb_pkg::MODE_SINGLE: begin
              if (dsp_bad) begin
                bad_nxt   = 1'b1;
                state_nxt = S_STAT;
              end else begin
                state_nxt = S_WORDS;
              end
            end
            default: begin
              state_nxt = S_WORDS;
            end
          endcase
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = lmfb_pkg::KIND_STATUS;
          oaddr_nxt     = 4'd0;
          odata_nxt     = 8'd0;
          fend_nxt      = 1'b0;
          last_nxt      = 1'b1;
          status_nxt    = lmfb_pkg::ST_INVALID;
          bad_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      S_PIX: begin
        if (out_free) begin
          store_req.wr_en   = 1'b1;
          store_req.addr    = pix_idx_r;
          store_req.wr_data = pix_byte;
          out_valid_nxt     = 1'b1;
          kind_nxt          = lmfb_pkg::KIND_STATUS;
          oaddr_nxt         = 4'd0;
          odata_nxt         = 8'd0;
          fend_nxt          = 1'b0;
          last_nxt          = 1'b1;
          status_nxt        = lmfb_pkg::ST_OK;
          state_nxt         = S_IDLE;
        end
      end
      S_FL_RD: begin
        store_req.rd_en = 1'b1;
        store_req.addr  = {disp_r, row_r};
        state_nxt       = S_FL_EMIT;
      end
      S_FL_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = lmfb_pkg::KIND_WORD;
          oaddr_nxt     = {1'b0, row_r} + 4'd1;
          odata_nxt     = store_rd_data;
          fend_nxt      = disp_end;
          last_nxt      = disp_end && (row_r == 3'(lmfb_pkg::ROWS - 1));
          status_nxt    = lmfb_pkg::ST_OK;
          state_nxt     = S_FL_RD;
          if (disp_end) begin
            disp_nxt = '0;
            if (row_r == 3'(lmfb_pkg::ROWS - 1)) begin
              state_nxt = S_IDLE;
            end else begin
              row_nxt = row_r + 3'd1;
            end
          end else begin
            disp_nxt = disp_r + 3'd1;
          end
        end
      end
      S_WORDS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = lmfb_pkg::KIND_WORD;
          oaddr_nxt     = (bcast_r || (disp_r == dsp_r)) ? raddr_r : 4'd0;
          odata_nxt     = (bcast_r || (disp_r == dsp_r)) ? rdata_r : 8'd0;
          fend_nxt      = disp_end;
          last_nxt      = disp_end;
          status_nxt    = lmfb_pkg::ST_OK;
          if (disp_end) begin
            disp_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            disp_nxt = disp_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bad_r       <= 1'b0;
      row_r       <= '0;
      disp_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bad_r       <= bad_nxt;
      row_r       <= row_nxt;
      disp_r      <= disp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bcast_r   <= bcast_nxt;
    dsp_r     <= dsp_nxt;
    raddr_r   <= raddr_nxt;
    rdata_r   <= rdata_nxt;
    bit_r     <= bit_nxt;
    val_r     <= val_nxt;
    pix_idx_r <= pix_idx_nxt;
    kind_r    <= kind_nxt;
    oaddr_r   <= oaddr_nxt;
    odata_r   <= odata_nxt;
    fend_r    <= fend_nxt;
    last_r    <= last_nxt;
    status_r  <= status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_addr      = oaddr_r;
  assign out_data      = odata_r;
  assign out_frame_end = fend_r;
  assign out_last      = last_r;
  assign out_status    = status_r;

endmodule

>>> rtl/core/led_matrix_framebuffer_serializer.sv
// Channel   | Ports                                           | Transfer when
// ----------+-------------------------------------------------+------------------------
// command   | in_valid, in_stall, in_mode .. in_display_index | in_valid && !in_stall
// result    | out_valid, out_stall, out_kind .. out_status    | out_valid && !out_stall
// config    | cfg_wr_en, cfg_wr_data                          | cfg_wr_en
//
// One command at a time; in_stall is high from transfer until its last result is
// loaded into the output register.
// Set pixel does a store read, then the write-back with the status; invalid commands give only a status.
// Flush: each word is a store read followed by its emit, through the single store read port.
// Broadcast / single write: one word per display in use.
// Sync reset clears the store valid bits at once; out_stall holds the output and sequencer.
module led_matrix_framebuffer_serializer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_mode,
  input  logic [7:0] in_pixel_column,
  input  logic [7:0] in_pixel_row,
  input  logic [7:0] in_pixel_value,
  input  logic [3:0] in_reg_addr,
  input  logic [7:0] in_reg_data,
  input  logic [7:0] in_display_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [3:0] out_addr,
  output logic [7:0] out_data,
  output logic       out_frame_end,
  output logic       out_last,
  output logic       out_status
);

  logic [3:0]                       display_count_r;
  logic [lmfb_pkg::DISP_W-1:0]      last_disp;
  lmfb_pkg::lmfb_store_req_t        store_req;
  logic [7:0]                       store_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_count_r <= lmfb_pkg::DISPLAY_COUNT_RST;
    end else if (cfg_wr_en) begin
      display_count_r <= cfg_wr_data;
    end
  end

  // index of the last display in use: count 0 acts as 1, above max acts as max
  always_comb begin
    if (display_count_r == 4'd0) begin
      last_disp = '0;
    end else if (display_count_r > 4'(lmfb_pkg::MAX_DISPLAYS)) begin
      last_disp = lmfb_pkg::DISP_W'(lmfb_pkg::MAX_DISPLAYS - 1);
    end else begin
      last_disp = lmfb_pkg::DISP_W'(display_count_r - 4'd1);
    end
  end

  lmfb_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .last_disp        (last_disp),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_pixel_column  (in_pixel_column),
    .in_pixel_row     (in_pixel_row),
    .in_pixel_value   (in_pixel_value),
    .in_reg_addr      (in_reg_addr),
    .in_reg_data      (in_reg_data),
    .in_display_index (in_display_index),
    .store_req        (store_req),
    .store_rd_data    (store_rd_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_addr         (out_addr),
    .out_data         (out_data),
    .out_frame_end    (out_frame_end),
    .out_last         (out_last),
    .out_status       (out_status)
  );

  lmfb_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (store_req),
    .rd_data (store_rd_data)
  );

endmodule
